FILE: rtl/core/rtpu_pkg.sv
// ----------------------------------------------------------------------------
// rtpu_pkg
// shared types and constants of the realtime thread picker
// ----------------------------------------------------------------------------
package rtpu_pkg;

  localparam int unsigned TIME_W = 31;
  localparam int unsigned ID_W   = 8;
  localparam int unsigned SLICE_W = 32;

  // command codes
  localparam logic [1:0] CMD_ADD_RUN = 2'd0;
  localparam logic [1:0] CMD_ADD_REL = 2'd1;
  localparam logic [1:0] CMD_SCHED   = 2'd2;

  // policy codes
  localparam logic [1:0] POL_ID  = 2'd0;
  localparam logic [1:0] POL_EDF = 2'd1;
  localparam logic [1:0] POL_RM  = 2'd2;

  localparam logic [TIME_W-1:0] NO_EVENT = 31'd99999;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] remaining;
    logic [TIME_W-1:0] period;
  } run_entry_t;

  typedef struct packed {
    logic [TIME_W-1:0] rel_time;
    logic [TIME_W-1:0] period;
    logic [ID_W-1:0]   id;
    logic              active;
  } rel_entry_t;

endpackage

FILE: rtl/core/rtpu_cell.sv
// ----------------------------------------------------------------------------
// rtpu_cell
// one table slot: loads a new entry or takes its neighbor's entry
// ----------------------------------------------------------------------------
module rtpu_cell #(
  parameter int unsigned W = 1
) (
  input  logic         clk_i,
  input  logic         ld_i,
  input  logic [W-1:0] ld_data_i,
  input  logic         sh_i,
  input  logic [W-1:0] sh_data_i,
  output logic [W-1:0] data_o
);

  logic [W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ld_i) begin
      data_d = ld_data_i;
    end else if (sh_i) begin
      data_d = sh_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: rtl/core/realtime_thread_picker_unit.sv
// ----------------------------------------------------------------------------
// realtime_thread_picker_unit
// edf / rate-monotonic thread picker over a run table and a release table
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_stall_o with command, thread and time fields.
//   add-run and add-release beats give no result.
//   a schedule beat gives exactly one output beat and then empties both tables.
// output channel: out_valid_o / out_stall_i; the result sits in an output
//   register until taken, and inserts are still accepted meanwhile.
// each table is a row of cells; a schedule rotates both rows toward cell 0,
//   one entry per cycle, and a scanner keeps the running best.
// a schedule beat steps through the run scan, the release scan, FIN1 and FIN2
//   before its result is loaded into the output register; empty scans are skipped.
// a new schedule beat is stalled while a result still waits at the output.
// the user writes the policy through policy_we_i only while idle; no check enforces it.
// reset empties both tables, clears the overflow flag, selects edf.
// a stalled output keeps its payload unchanged.
// ----------------------------------------------------------------------------
module realtime_thread_picker_unit
  import rtpu_pkg::*;
#(
  parameter int unsigned RUN_DEPTH = 16,
  parameter int unsigned REL_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                policy_we_i,
  input  logic [1:0]          policy_i,
  // input beats
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          command_i,
  input  logic [ID_W-1:0]     thread_id_i,
  input  logic [TIME_W-1:0]   deadline_i,
  input  logic [TIME_W-1:0]   remaining_i,
  input  logic [TIME_W-1:0]   period_len_i,
  input  logic [TIME_W-1:0]   release_at_i,
  input  logic                jobs_left_i,
  input  logic [TIME_W-1:0]   now_i,
  // result beats
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                busy_res_o,
  output logic [ID_W-1:0]     chosen_id_o,
  output logic signed [SLICE_W-1:0] slice_o,
  output logic                missed_o,
  output logic                overflow_o
);

  localparam int unsigned RUN_CW = $clog2(RUN_DEPTH + 1);
  localparam int unsigned REL_CW = $clog2(REL_DEPTH + 1);
  localparam int unsigned SCW = (RUN_CW > REL_CW) ? RUN_CW : REL_CW;
  localparam int unsigned RUN_W = $bits(run_entry_t);
  localparam int unsigned REL_W = $bits(rel_entry_t);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RUN  = 5'b00010,
    ST_REL  = 5'b00100,
    ST_FIN1 = 5'b01000,
    ST_FIN2 = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]        policy_q;
  logic [RUN_CW-1:0] run_cnt_q, run_cnt_d;
  logic [REL_CW-1:0] rel_cnt_q, rel_cnt_d;
  logic              dropped_q, dropped_d;
  logic [SCW-1:0]    scan_q, scan_d;
  logic [TIME_W-1:0] now_q;

  // scanner registers
  logic [ID_W-1:0]   bid_q;
  logic [TIME_W-1:0] bdl_q, brem_q, bper_q;
  logic              have_miss_q;
  logic [ID_W-1:0]   miss_id_q;
  logic              have_rel_q;
  logic [SLICE_W-1:0] pkey_q;
  logic [TIME_W-1:0] ptime_q;
  logic [ID_W-1:0]   pid_q;
  logic [TIME_W-1:0] least_q;
  logic signed [SLICE_W:0] t_rel_q, t_dl_q;

  // output register
  logic              out_valid_q;
  logic              busy_q, missed_q, ovf_q;
  logic [ID_W-1:0]   id_q;
  logic [SLICE_W-1:0] slice_q;

  logic in_acc, out_acc;
  logic is_edf, is_rm, prio;
  logic run_sh, rel_sh;
  logic ins_run, ins_rel;

  assign in_acc  = in_valid_i & ~in_stall_o;
  assign out_acc = out_valid_q & ~out_stall_i;
  assign is_edf  = (policy_q == POL_EDF);
  assign is_rm   = (policy_q == POL_RM);
  assign prio    = is_edf | is_rm;

  assign in_stall_o = (state_q != ST_IDLE) | (out_valid_q & (command_i == CMD_SCHED));

  assign ins_run = in_acc & (command_i == CMD_ADD_RUN) & (run_cnt_q < RUN_CW'(RUN_DEPTH));
  assign ins_rel = in_acc & (command_i == CMD_ADD_REL) & (rel_cnt_q < REL_CW'(REL_DEPTH));
  assign run_sh  = (state_q == ST_RUN);
  assign rel_sh  = (state_q == ST_REL);

  // ---- run table: a row of cells rotating toward cell 0 during the scan
  run_entry_t run_new;
  logic [RUN_W-1:0] run_data [RUN_DEPTH];
  run_entry_t run_head;

  assign run_new = '{id: thread_id_i, deadline: deadline_i,
                     remaining: remaining_i, period: period_len_i};

  for (genvar i = 0; i < RUN_DEPTH; i++) begin : g_run
    rtpu_cell #(.W(RUN_W)) u_cell (
      .clk_i     (clk_i),
      .ld_i      (ins_run & (run_cnt_q == RUN_CW'(i))),
      .ld_data_i (run_new),
      .sh_i      (run_sh),
      .sh_data_i (run_data[(i + 1) % RUN_DEPTH]),
      .data_o    (run_data[i])
    );
  end
  assign run_head = run_entry_t'(run_data[0]);

  // ---- release table
  rel_entry_t rel_new;
  logic [REL_W-1:0] rel_data [REL_DEPTH];
  rel_entry_t rel_head;

  assign rel_new = '{rel_time: release_at_i, period: period_len_i,
                     id: thread_id_i, active: jobs_left_i};

  for (genvar i = 0; i < REL_DEPTH; i++) begin : g_rel
    rtpu_cell #(.W(REL_W)) u_cell (
      .clk_i     (clk_i),
      .ld_i      (ins_rel & (rel_cnt_q == REL_CW'(i))),
      .ld_data_i (rel_new),
      .sh_i      (rel_sh),
      .sh_data_i (rel_data[(i + 1) % REL_DEPTH]),
      .data_o    (rel_data[i])
    );
  end
  assign rel_head = rel_entry_t'(rel_data[0]);

  // ---- scan control
  logic [SCW-1:0] scan_nx;
  logic run_last, rel_last, run_empty, rel_empty;

  assign scan_nx   = scan_q + SCW'(1);
  assign run_last  = (scan_nx == SCW'(run_cnt_q));
  assign rel_last  = (scan_nx == SCW'(rel_cnt_q));
  assign run_empty = (run_cnt_q == '0);
  assign rel_empty = (rel_cnt_q == '0);

  always_comb begin
    state_d   = state_q;
    scan_d    = scan_q;
    run_cnt_d = run_cnt_q;
    rel_cnt_d = rel_cnt_q;
    dropped_d = dropped_q;
    if (ins_run) begin
      run_cnt_d = run_cnt_q + RUN_CW'(1);
    end
    if (ins_rel) begin
      rel_cnt_d = rel_cnt_q + REL_CW'(1);
    end
    if (in_acc & (command_i == CMD_ADD_RUN) & ~ins_run) begin
      dropped_d = 1'b1;
    end
    if (in_acc & (command_i == CMD_ADD_REL) & ~ins_rel) begin
      dropped_d = 1'b1;
    end
    case (state_q)
      ST_IDLE: begin
        scan_d = '0;
        if (in_acc & (command_i == CMD_SCHED)) begin
          if (!run_empty) begin
            state_d = ST_RUN;
          end else if (!rel_empty) begin
            state_d = ST_REL;
          end else begin
            state_d = ST_FIN1;
          end
        end
      end
      ST_RUN: begin
        scan_d = scan_nx;
        if (run_last) begin
          scan_d  = '0;
          state_d = rel_empty ? ST_FIN1 : ST_REL;
        end
      end
      ST_REL: begin
        scan_d = scan_nx;
        if (rel_last) begin
          scan_d  = '0;
          state_d = ST_FIN1;
        end
      end
      ST_FIN1: state_d = ST_FIN2;
      ST_FIN2: begin
        state_d   = ST_IDLE;
        run_cnt_d = '0;
        rel_cnt_d = '0;
        dropped_d = 1'b0;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---- run scan compare
  logic first;
  logic [TIME_W-1:0] key_e, key_b;
  logic run_better, run_miss;

  assign first = (scan_q == '0);
  assign key_e = is_edf ? run_head.deadline : run_head.period;
  assign key_b = is_edf ? bdl_q : bper_q;

  always_comb begin
    if (first) begin
      run_better = 1'b1;
    end else if (prio) begin
      run_better = (key_e < key_b) | ((key_e == key_b) & (run_head.id < bid_q));
    end else begin
      run_better = (run_head.id < bid_q);
    end
  end
  assign run_miss = (run_head.deadline <= now_q) & (~have_miss_q | (run_head.id < miss_id_q));

  // ---- release scan compare
  logic [SLICE_W-1:0] sum_e, key_r;
  logic rel_cand, rel_take;

  assign sum_e = SLICE_W'(rel_head.period) + SLICE_W'(rel_head.rel_time);
  assign key_r = is_edf ? sum_e : SLICE_W'(rel_head.period);
  assign rel_cand = is_edf ? (rel_head.active & (sum_e < SLICE_W'(bdl_q)))
                           : (rel_head.period < bper_q);
  assign rel_take = rel_cand & (~have_rel_q | (key_r < pkey_q) |
                                ((key_r == pkey_q) & (rel_head.id < pid_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_miss_q <= 1'b0;
      have_rel_q  <= 1'b0;
    end else if (state_q == ST_IDLE) begin
      have_miss_q <= 1'b0;
      have_rel_q  <= 1'b0;
    end else if (state_q == ST_RUN) begin
      if (run_miss) begin
        have_miss_q <= 1'b1;
      end
    end else if (state_q == ST_REL) begin
      if (rel_take) begin
        have_rel_q <= 1'b1;
      end
    end
  end

  // scanner payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      now_q   <= now_i;
      least_q <= NO_EVENT;
    end
    if (run_sh & run_better) begin
      bid_q  <= run_head.id;
      bdl_q  <= run_head.deadline;
      brem_q <= run_head.remaining;
      bper_q <= run_head.period;
    end
    if (run_sh & run_miss) begin
      miss_id_q <= run_head.id;
    end
    if (rel_sh) begin
      if (rel_head.rel_time < least_q) begin
        least_q <= rel_head.rel_time;
      end
      if (rel_take) begin
        pkey_q  <= key_r;
        ptime_q <= rel_head.rel_time;
        pid_q   <= rel_head.id;
      end
    end
    if (state_q == ST_FIN1) begin
      // idle uses the earliest release, a thread uses the preempting one
      if (run_empty) begin
        t_rel_q <= $signed({2'b00, least_q}) - $signed({2'b00, now_q});
      end else if (have_rel_q) begin
        t_rel_q <= $signed({2'b00, ptime_q}) - $signed({2'b00, now_q});
      end else begin
        t_rel_q <= $signed({2'b00, NO_EVENT});
      end
      t_dl_q <= $signed({2'b00, bdl_q}) - $signed({2'b00, now_q});
    end
  end

  // ---- final selection into the output register
  logic signed [SLICE_W:0] rem_s, m1, m2;
  logic [SLICE_W-1:0] slice_d;
  logic [ID_W-1:0] id_d;

  assign rem_s = $signed({2'b00, brem_q});
  assign m1 = (t_rel_q < t_dl_q) ? t_rel_q : t_dl_q;
  assign m2 = (m1 < rem_s) ? m1 : rem_s;

  always_comb begin
    id_d = bid_q;
    if (!prio) begin
      slice_d = run_empty ? SLICE_W'(1) : SLICE_W'(brem_q);
    end else if (run_empty) begin
      slice_d = t_rel_q[SLICE_W-1:0];
    end else if (have_miss_q) begin
      slice_d = '0;
      id_d    = miss_id_q;
    end else begin
      slice_d = m2[SLICE_W-1:0];
    end
    if (run_empty) begin
      id_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN2) begin
      busy_q   <= ~run_empty;
      id_q     <= id_d;
      slice_q  <= slice_d;
      missed_q <= prio & ~run_empty & have_miss_q;
      ovf_q    <= dropped_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      policy_q    <= POL_EDF;
      run_cnt_q   <= '0;
      rel_cnt_q   <= '0;
      dropped_q   <= 1'b0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      run_cnt_q <= run_cnt_d;
      rel_cnt_q <= rel_cnt_d;
      dropped_q <= dropped_d;
      scan_q    <= scan_d;
      if (policy_we_i) begin
        policy_q <= policy_i;
      end
      if (state_q == ST_FIN2) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign busy_res_o  = busy_q;
  assign chosen_id_o = id_q;
  assign slice_o     = $signed(slice_q);
  assign missed_o    = missed_q;
  assign overflow_o  = ovf_q;

endmodule

FILE: rtl/core/rtpu_checker.sv
// ----------------------------------------------------------------------------
// rtpu_checker
// port-level checks of the realtime thread picker
// ----------------------------------------------------------------------------
module rtpu_checker
  import rtpu_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         command_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               busy_res_o,
  input logic [ID_W-1:0]    chosen_id_o,
  input logic signed [SLICE_W-1:0] slice_o,
  input logic               missed_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(slice_o) && $stable(chosen_id_o))
    else $error("stalled result changed");

  a_sched_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && command_i == CMD_SCHED |=> in_stall_o)
    else $error("schedule beat did not occupy the block");

  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> chosen_id_o == '0 && !missed_o)
    else $error("idle result carries a thread");

  a_missed_slice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && missed_o |-> busy_res_o && slice_o == '0)
    else $error("missed result with nonzero slice");

endmodule

bind realtime_thread_picker_unit rtpu_checker u_rtpu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .command_i   (command_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .busy_res_o  (busy_res_o),
  .chosen_id_o (chosen_id_o),
  .slice_o     (slice_o),
  .missed_o    (missed_o)
);

FILE: tb/sv/tb_realtime_thread_picker_unit.sv
// ----------------------------------------------------------------------------
// tb_realtime_thread_picker_unit
// checks the thread picker against its own predictor of scheduling decisions:
// a short table of directed beats, then constrained-shape random sequences of
// table inserts closed by a schedule beat, under all policies and idling mixes
// ----------------------------------------------------------------------------
module tb_realtime_thread_picker_unit;
  import rtpu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TBL_DEPTH = 16;
  localparam int unsigned LIMIT     = 20000;
  localparam logic [1:0]  CMD_NONE  = 2'd3;   // undefined code, must be ignored
  localparam logic [1:0]  POL_ALT   = 2'd3;   // undefined policy, acts as by id

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ID_W-1:0]   tid;
    logic [TIME_W-1:0] dl;
    logic [TIME_W-1:0] rem;
    logic [TIME_W-1:0] per;
    logic [TIME_W-1:0] rel;
    logic              act;
    logic [TIME_W-1:0] now;
  } beat_t;

  typedef struct packed {
    logic               busy;
    logic [ID_W-1:0]    id;
    logic [SLICE_W-1:0] slice;
    logic               missed;
    logic               ovf;
  } pick_t;

  // directed row: a beat plus an optional hand-written expectation
  typedef struct packed {
    beat_t b;
    logic  typed;
    pick_t want;
  } row_t;

  logic clk_i, rst_ni;
  logic policy_we_i;
  logic [1:0] policy_i;
  logic in_valid_i, in_stall_o;
  logic [1:0] command_i;
  logic [ID_W-1:0] thread_id_i;
  logic [TIME_W-1:0] deadline_i, remaining_i, period_len_i, release_at_i, now_i;
  logic jobs_left_i;
  logic out_valid_o, out_stall_i;
  logic busy_res_o;
  logic [ID_W-1:0] chosen_id_o;
  logic signed [SLICE_W-1:0] slice_o;
  logic missed_o, overflow_o;

  realtime_thread_picker_unit dut (
    .clk_i, .rst_ni,
    .policy_we_i, .policy_i,
    .in_valid_i, .in_stall_o,
    .command_i, .thread_id_i, .deadline_i, .remaining_i,
    .period_len_i, .release_at_i, .jobs_left_i, .now_i,
    .out_valid_o, .out_stall_i,
    .busy_res_o, .chosen_id_o, .slice_o, .missed_o, .overflow_o
  );

  // predictor copy of the block's tables
  logic [1:0] pol_q;
  run_entry_t run_tbl[TBL_DEPTH];
  rel_entry_t rel_tbl[TBL_DEPTH];
  int unsigned run_n, rel_n;
  logic drop_q;

  pick_t picks_due[$];
  int unsigned n_bad;
  int unsigned idle_cycles;
  int unsigned send_idle_pct, recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // scheduling decision for the current tables; 64-bit signed math for time arithmetic
  function automatic pick_t decide(logic [TIME_W-1:0] now_t);
    pick_t r;
    longint t, lo, bnd;
    int unsigned best, miss, pre;
    bit have_miss, have_pre;
    logic [TIME_W-1:0] kb, ki;
    longint s, ps;
    r = '0;
    t = longint'(now_t);
    if (pol_q != POL_EDF && pol_q != POL_RM) begin
      if (run_n == 0) begin
        r.slice = 32'd1;
      end else begin
        best = 0;
        for (int i = 1; i < run_n; i++)
          if (run_tbl[i].id < run_tbl[best].id) best = i;
        r.busy = 1'b1;
        r.id = run_tbl[best].id;
        r.slice = {1'b0, run_tbl[best].remaining};
      end
    end else if (run_n == 0) begin
      // idle: time until the earliest release, may go negative
      lo = 99999;
      for (int i = 0; i < rel_n; i++)
        if (longint'(rel_tbl[i].rel_time) < lo) lo = longint'(rel_tbl[i].rel_time);
      r.slice = SLICE_W'(lo - t);
    end else begin
      have_miss = 0; miss = 0; best = 0;
      for (int i = 0; i < run_n; i++) begin
        if (longint'(run_tbl[i].deadline) <= t &&
            (!have_miss || run_tbl[i].id < run_tbl[miss].id)) begin
          miss = i;
          have_miss = 1;
        end
        if (i > 0) begin
          ki = (pol_q == POL_EDF) ? run_tbl[i].deadline : run_tbl[i].period;
          kb = (pol_q == POL_EDF) ? run_tbl[best].deadline : run_tbl[best].period;
          if (ki < kb || (ki == kb && run_tbl[i].id < run_tbl[best].id)) best = i;
        end
      end
      r.busy = 1'b1;
      if (have_miss) begin
        r.id = run_tbl[miss].id;
        r.missed = 1'b1;
      end else begin
        r.id = run_tbl[best].id;
        have_pre = 0; pre = 0;
        for (int i = 0; i < rel_n; i++) begin
          if (pol_q == POL_EDF) begin
            s = longint'(rel_tbl[i].period) + longint'(rel_tbl[i].rel_time);
            ps = longint'(rel_tbl[pre].period) + longint'(rel_tbl[pre].rel_time);
            if (s < longint'(run_tbl[best].deadline) && rel_tbl[i].active &&
                (!have_pre || s < ps || (s == ps && rel_tbl[pre].id > rel_tbl[i].id))) begin
              pre = i;
              have_pre = 1;
            end
          end else if (rel_tbl[i].period < run_tbl[best].period &&
                       (!have_pre || rel_tbl[pre].period > rel_tbl[i].period ||
                        (rel_tbl[pre].period == rel_tbl[i].period &&
                         rel_tbl[pre].id > rel_tbl[i].id))) begin
            pre = i;
            have_pre = 1;
          end
        end
        bnd = have_pre ? longint'(rel_tbl[pre].rel_time) - t : 99999;
        if (longint'(run_tbl[best].deadline) - t < bnd)
          bnd = longint'(run_tbl[best].deadline) - t;
        if (longint'(run_tbl[best].remaining) < bnd)
          bnd = longint'(run_tbl[best].remaining);
        r.slice = SLICE_W'(bnd);
      end
    end
    r.ovf = drop_q;
    return r;
  endfunction

  // apply one accepted beat to the predictor, returning 1 if a pick results
  function automatic bit absorb(beat_t b, output pick_t p);
    p = '0;
    case (b.cmd)
      CMD_ADD_RUN: begin
        if (run_n < TBL_DEPTH) begin
          run_tbl[run_n] = '{id: b.tid, deadline: b.dl, remaining: b.rem, period: b.per};
          run_n++;
        end else drop_q = 1'b1;
      end
      CMD_ADD_REL: begin
        if (rel_n < TBL_DEPTH) begin
          rel_tbl[rel_n] = '{rel_time: b.rel, period: b.per, id: b.tid, active: b.act};
          rel_n++;
        end else drop_q = 1'b1;
      end
      CMD_SCHED: begin
        p = decide(b.now);
        run_n = 0;
        rel_n = 0;
        drop_q = 1'b0;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // drive one beat and hold it until accepted; sender gaps before it
  task automatic send_beat(beat_t b, bit typed, pick_t want);
    pick_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= b.cmd;
    thread_id_i  <= b.tid;
    deadline_i   <= b.dl;
    remaining_i  <= b.rem;
    period_len_i <= b.per;
    release_at_i <= b.rel;
    jobs_left_i  <= b.act;
    now_i        <= b.now;
    do @(posedge clk_i); while (in_stall_o);
    if (absorb(b, p)) picks_due.push_back(typed ? want : p);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_policy(logic [1:0] v);
    policy_we_i <= 1'b1;
    policy_i    <= v;
    @(posedge clk_i);
    policy_we_i <= 1'b0;
    pol_q = v;
  endtask

  function automatic logic [TIME_W-1:0] rand_time(logic [TIME_W-1:0] base);
    case ($urandom_range(9))
      0: return TIME_W'($urandom);
      1: return '1;
      2: return '0;
      default: return base + TIME_W'($urandom_range(300));
    endcase
  endfunction

  function automatic beat_t rand_beat(logic [1:0] cmd, logic [TIME_W-1:0] base);
    beat_t b;
    b.cmd = cmd;
    b.tid = ($urandom_range(3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(12));
    b.dl  = rand_time(base);
    b.rem = ($urandom_range(4) == 0) ? TIME_W'($urandom) : TIME_W'($urandom_range(400));
    b.per = ($urandom_range(4) == 0) ? TIME_W'($urandom) : TIME_W'($urandom_range(300));
    b.rel = rand_time(base);
    b.act = 1'($urandom_range(1));
    b.now = rand_time(base);
    return b;
  endfunction

  // receiver: random stall, compare each accepted result with the oldest pick
  always @(posedge clk_i) begin
    pick_t got, exp_p;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{busy: busy_res_o, id: chosen_id_o, slice: slice_o,
                missed: missed_o, ovf: overflow_o};
        if (picks_due.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected result beat: %p", got);
        end else begin
          exp_p = picks_due.pop_front();
          if (got !== exp_p) begin
            n_bad++;
            if (n_bad <= 10)
              $display("result mismatch: expected %p, got %p", exp_p, got);
          end
        end
      end
      idle_cycles <= ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
                     ? 0 : idle_cycles + 1;
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (idle_cycles >= LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // directed table
  row_t rows[$];

  function automatic beat_t mk(logic [1:0] c, logic [ID_W-1:0] id, int unsigned dl,
                               int unsigned rem, int unsigned per, int unsigned rel,
                               bit act, int unsigned now_t);
    return '{cmd: c, tid: id, dl: TIME_W'(dl), rem: TIME_W'(rem), per: TIME_W'(per),
             rel: TIME_W'(rel), act: act, now: TIME_W'(now_t)};
  endfunction

  function automatic pick_t pk(bit bz, logic [ID_W-1:0] id, int s, bit m, bit o);
    return '{busy: bz, id: id, slice: s, missed: m, ovf: o};
  endfunction

  initial begin
    pick_t none;
    logic [TIME_W-1:0] base;
    int unsigned fill;
    none = '0;
    rst_ni = 1'b0;
    policy_we_i = 1'b0; policy_i = POL_EDF;
    in_valid_i = 1'b0; command_i = CMD_ADD_RUN; thread_id_i = '0;
    deadline_i = '0; remaining_i = '0; period_len_i = '0;
    release_at_i = '0; jobs_left_i = 1'b0; now_i = '0;
    out_stall_i = 1'b0;
    n_bad = 0; idle_cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    pol_q = POL_EDF; run_n = 0; rel_n = 0; drop_q = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // edf after reset: idle with empty tables, slice is the no-event horizon minus now
    rows.push_back('{mk(CMD_SCHED, 0, 0, 0, 0, 0, 0, 0), 1'b1, pk(0, 0, 99999, 0, 0)});
    // idle with now at maximum: negative slice
    rows.push_back('{mk(CMD_SCHED, 0, 0, 0, 0, 0, 0, 32'h7fffffff), 1'b1,
                     pk(0, 0, 99999 - 32'sh7fffffff, 0, 0)});
    // idle bounded by an earlier release
    rows.push_back('{mk(CMD_ADD_REL, 5, 0, 0, 7, 500, 1, 0), 1'b0, none});
    rows.push_back('{mk(CMD_SCHED, 0, 0, 0, 0, 0, 0, 100), 1'b1, pk(0, 0, 400, 0, 0)});
    // missed deadline: smallest id among the late ones
    rows.push_back('{mk(CMD_ADD_RUN, 9, 50, 10, 3, 0, 0, 0), 1'b0, none});
    rows.push_back('{mk(CMD_ADD_RUN, 4, 60, 10, 3, 0, 0, 0), 1'b0, none});
    rows.push_back('{mk(CMD_ADD_RUN, 2, 900, 10, 3, 0, 0, 0), 1'b0, none});
    rows.push_back('{mk(CMD_SCHED, 0, 0, 0, 0, 0, 0, 60), 1'b1, pk(1, 4, 0, 1, 0)});
    // edf with a preempting release, extremes of the run fields
    rows.push_back('{mk(CMD_ADD_RUN, 255, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0),
                     1'b0, none});
    rows.push_back('{mk(CMD_ADD_REL, 255, 0, 0, 32'h7fffffff, 32'h7fffffff, 1, 0), 1'b0, none});
    rows.push_back('{mk(CMD_ADD_REL, 3, 0, 0, 10, 200, 1, 0), 1'b0, none});
    rows.push_back('{mk(CMD_ADD_REL, 1, 0, 0, 10, 200, 0, 0), 1'b0, none});
    rows.push_back('{mk(CMD_SCHED, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
    // undefined command gives nothing
    rows.push_back('{mk(CMD_NONE, 8'hff, '1, '1, '1, '1, 1, '1), 1'b0, none});
    foreach (rows[i]) send_beat(rows[i].b, rows[i].typed, rows[i].want);
    drain();

    // overflow on both tables under rate monotonic
    set_policy(POL_RM);
    for (int i = 0; i < TBL_DEPTH + 1; i++) begin
      send_beat(mk(CMD_ADD_RUN, ID_W'(i), 1000, 50, 100 - i, 0, 0, 0), 1'b0, none);
      send_beat(mk(CMD_ADD_REL, ID_W'(i), 0, 0, 60 + i, 30 + i, 0, 0), 1'b0, none);
    end
    send_beat(mk(CMD_SCHED, 0, 0, 0, 0, 0, 0, 10), 1'b0, none);
    // policy by id, idle then busy
    drain();
    set_policy(POL_ID);
    send_beat(mk(CMD_SCHED, 0, 0, 0, 0, 0, 0, 77), 1'b1, pk(0, 0, 1, 0, 0));
    send_beat(mk(CMD_ADD_RUN, 6, 0, 33, 0, 0, 0, 0), 1'b0, none);
    send_beat(mk(CMD_ADD_RUN, 5, 0, 44, 0, 0, 0, 0), 1'b0, none);
    send_beat(mk(CMD_SCHED, 0, 0, 0, 0, 0, 0, 77), 1'b1, pk(1, 5, 44, 0, 0));
    drain();

    // random phases: policy cycles through all codes, idling mixes vary
    for (int ph = 0; ph < 8; ph++) begin
      set_policy(ph % 4 == 0 ? POL_EDF : ph % 4 == 1 ? POL_RM :
                 ph % 4 == 2 ? POL_ID : POL_ALT);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      for (int s = 0; s < 18; s++) begin
        base = TIME_W'($urandom_range(1000));
        fill = ($urandom_range(7) == 0) ? $urandom_range(20) : $urandom_range(6);
        for (int k = 0; k < fill; k++) begin
          send_beat(rand_beat($urandom_range(9) == 0 ? CMD_NONE :
                              $urandom_range(1) ? CMD_ADD_RUN : CMD_ADD_REL, base),
                    1'b0, none);
        end
        send_beat(rand_beat(CMD_SCHED, base), 1'b0, none);
        // sender holds off until every pick is back
        if (s == 5) begin
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (picks_due.size() != 0);
        end
      end
      drain();
    end
    recv_stall_pct = 0;
    drain();

    if (n_bad == 0 && picks_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: realtime_thread_picker_unit.f
rtl/core/rtpu_pkg.sv
rtl/core/rtpu_cell.sv
rtl/core/realtime_thread_picker_unit.sv
rtl/core/rtpu_checker.sv
tb/sv/tb_realtime_thread_picker_unit.sv
